FILE: hw/rtl/bwt_symbol_histogram_ctable_unit_assert.svh
// Assertion macros shared by the symbol histogram RTL.
`ifndef BWT_SYMBOL_HISTOGRAM_CTABLE_UNIT_ASSERT_SVH
`define BWT_SYMBOL_HISTOGRAM_CTABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The condition pre implies post in the same cycle.
`define BSHC_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");
// The condition pre implies post in the next cycle.
`define BSHC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next cycle check failed");
`else
`define BSHC_ASSERT_IMPLY(label, clk, rst, pre, post)
`define BSHC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: hw/rtl/bshc_pkg.sv
// Types, constants and codes shared by the symbol histogram modules.
`default_nettype none
package bshc_pkg;

   localparam int DEF_NUM_BINS    = 96;
   localparam int DEF_COUNT_BITS  = 32;
   localparam int DEF_QUEUE_DEPTH = 4;

   localparam int REQ_TYPE_W = 2;
   localparam int SYMBOL_W   = 8;
   localparam int INDEX_W    = 7;
   localparam int OUT_CNT_W  = 32;
   localparam int START_W    = 33;

   localparam logic [SYMBOL_W-1:0] DELIM_RESET = 8'd36;
   localparam logic [SYMBOL_W-1:0] TAB_BYTE    = 8'd9;
   localparam logic [8:0]          SHIFT_LO    = 9'd30;
   localparam logic [8:0]          SHIFT_HI    = 9'd31;
   localparam logic [START_W-1:0]  START_NONE  = '1;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_COUNT = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NOP   = 2'd3
   } req_code_type;

   // Command classes handed from the front end to the back end.
   typedef enum logic [2:0] {
      CMD_ZERO,
      CMD_COUNT,
      CMD_QUERY,
      CMD_QUERY_OOR,
      CMD_CLEAR
   } cmd_code_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_COUNT,
      BK_QUERY
   } back_state_type;

   typedef struct packed {
      cmd_code_type        cmd;
      logic [INDEX_W-1:0]  bin;
      logic [SYMBOL_W-1:0] char_code;
   } queue_entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic idle;
      logic any_valid;
      logic clear_fire;
   } back_status_type;

endpackage
`default_nettype wire

FILE: hw/rtl/bshc_channels.sv
// Handshake channel interfaces for requests, results and the delimiter register.
`default_nettype none
interface bshc_req_if;
   import bshc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SYMBOL_W-1:0]   symbol;
   logic [INDEX_W-1:0]    entry_index;
   modport source (output valid, req_type, symbol, entry_index, input ready);
   modport sink (input valid, req_type, symbol, entry_index, output ready);
endinterface

interface bshc_rsp_if;
   import bshc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [INDEX_W-1:0]        bin_index;
   logic                      symbol_ok;
   logic [OUT_CNT_W-1:0]      bin_count;
   logic signed [START_W-1:0] start_offset;
   logic [SYMBOL_W-1:0]       entry_char;
   modport source (output valid, bin_index, symbol_ok, bin_count, start_offset, entry_char,
                   input ready);
   modport sink (input valid, bin_index, symbol_ok, bin_count, start_offset, entry_char,
                 output ready);
endinterface

interface bshc_csr_if;
   import bshc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] wdata;
   modport source (output valid, wdata, input ready);
   modport sink (input valid, wdata, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/bwt_symbol_histogram_ctable_unit.sv
// Top level of the symbol histogram and C table unit.
//
//   Channel    Direction  Carries
//   req_chan   in         req_type, symbol, entry_index
//   rsp_chan   out        bin_index, symbol_ok, bin_count, start_offset, entry_char
//   csr_chan   in         wdata: the delimiter byte, always ready
//
// A count reads the counter and then writes it back through the counter RAM. A query of
// bin k reads bins 0 to k, one counter read per cycle, to form the prefix sum. Clear, no
// operation, rejected bytes and out of range queries are answered from the idle state.
// Reset is synchronous; a clear marks every counter empty at once through per bin valid
// bits, so there is no clearing pass. The front end keeps accepting into the queue, while
// it is not full, while the back end works or while a result waits in the output register.
`default_nettype none
`include "bwt_symbol_histogram_ctable_unit_assert.svh"
module bwt_symbol_histogram_ctable_unit #(
   parameter int NUM_BINS    = bshc_pkg::DEF_NUM_BINS,
   parameter int COUNT_BITS  = bshc_pkg::DEF_COUNT_BITS,
   parameter int QUEUE_DEPTH = bshc_pkg::DEF_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   bshc_req_if.sink   req_chan,
   bshc_rsp_if.source rsp_chan,
   bshc_csr_if.sink   csr_chan
);
   import bshc_pkg::*;

   // The delimiter register. The user must write it only while the unit is idle, so that the
   // front end and queued entries always see one consistent value; the unit does not enforce it.
   logic [SYMBOL_W-1:0] delimiter_ff, delimiter_in;

   queue_status_type q_status;
   queue_entry_type  push_entry;
   queue_entry_type  head_entry;
   logic             q_push;
   logic             q_pop;
   back_status_type  back_status;

   // Result conditions that the checks below refer to.
   logic             rsp_reject;
   logic             rsp_empty_bin;
   logic             rsp_start_none;

   assign csr_chan.ready = 1'b1;
   assign delimiter_in   = csr_chan.valid ? csr_chan.wdata : delimiter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DELIM_RESET;
      end else begin
         delimiter_ff <= delimiter_in;
      end
   end

   // Front end: maps each request to a command with its bin and byte already worked out.
   bshc_front #(
      .NUM_BINS (NUM_BINS)
   ) u_front (
      .req       (req_chan),
      .delimiter (delimiter_ff),
      .q_status  (q_status),
      .q_push    (q_push),
      .q_entry   (push_entry)
   );

   // The queue decouples request acceptance from counter updates and scans.
   bshc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .pop_entry  (head_entry),
      .status     (q_status)
   );

   // Back end: owns the counter RAM and the result register.
   bshc_back #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_entry  (head_entry),
      .q_pop    (q_pop),
      .status   (back_status),
      .rsp      (rsp_chan)
   );

   assign rsp_reject     = rsp_chan.valid && !rsp_chan.symbol_ok;
   assign rsp_empty_bin  = rsp_chan.valid && rsp_chan.symbol_ok && (rsp_chan.bin_count == '0);
   assign rsp_start_none = (rsp_chan.start_offset == START_NONE);

   // A result that is not marked ok never reports a count.
   `BSHC_ASSERT_IMPLY(a_reject_zero_count, clock, reset, rsp_reject, rsp_chan.bin_count == '0)
   // An empty bin that lies in the table has no start offset.
   `BSHC_ASSERT_IMPLY(a_empty_bin_no_start, clock, reset, rsp_empty_bin, rsp_start_none)
   // After a clear leaves the queue, every counter reads as empty.
   `BSHC_ASSERT_NEXT(a_clear_empties_store, clock, reset, back_status.clear_fire, !back_status.any_valid)
   // A clear is only taken from the queue while the back end is idle.
   `BSHC_ASSERT_IMPLY(a_clear_from_idle, clock, reset, back_status.clear_fire, back_status.idle)
   // The front end never pushes into a full queue.
   `BSHC_ASSERT_IMPLY(a_no_push_when_full, clock, reset, q_status.full, !q_push)

endmodule
`default_nettype wire

FILE: hw/rtl/bshc_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module bshc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/bshc_queue.sv
// Small command queue between the front end and the back end.
`default_nettype none
module bshc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bshc_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output bshc_pkg::queue_entry_type  pop_entry,
   output bshc_pkg::queue_status_type status
);
   import bshc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type  entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign pop_entry    = entry_ff[rd_ptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));

endmodule
`default_nettype wire

FILE: hw/rtl/bshc_front.sv
// Front end: accepts requests, maps bytes to bins and classifies each item.
`default_nettype none
module bshc_front #(
   parameter int NUM_BINS = 96
) (
   bshc_req_if.sink                        req,
   input  logic [bshc_pkg::SYMBOL_W-1:0]   delimiter,
   input  bshc_pkg::queue_status_type      q_status,
   output logic                            q_push,
   output bshc_pkg::queue_entry_type       q_entry
);
   import bshc_pkg::*;

   logic [SYMBOL_W-1:0] sym;
   logic                is_delim;
   logic                is_tab;
   logic                below_delim;
   logic                under_low;
   logic [8:0]          bin_raw;
   logic                count_ok;
   logic                query_ok;
   logic [SYMBOL_W-1:0] char_base;
   logic [SYMBOL_W-1:0] query_char;

   assign req.ready = !q_status.full;
   assign q_push    = req.valid && !q_status.full;

   // Byte to bin: delimiter first, then tab, then the two shifted ranges.
   always_comb begin
      sym         = req.symbol;
      is_delim    = (sym == delimiter);
      is_tab      = (sym == TAB_BYTE);
      below_delim = (sym < delimiter);
      under_low   = below_delim ? ({1'b0, sym} < SHIFT_LO) : ({1'b0, sym} < SHIFT_HI);
      if (is_delim) begin
         bin_raw = 9'd0;
      end else if (is_tab) begin
         bin_raw = 9'd1;
      end else if (below_delim) begin
         bin_raw = {1'b0, sym} - SHIFT_LO;
      end else begin
         bin_raw = {1'b0, sym} - SHIFT_HI;
      end
      count_ok = !sym[SYMBOL_W-1] &&
                 (is_delim || is_tab || (!under_low && (bin_raw < 9'(NUM_BINS))));
   end

   // Bin to byte for queries, wrapping at 256 like the byte arithmetic.
   always_comb begin
      query_ok  = ({2'b00, req.entry_index} < 9'(NUM_BINS));
      char_base = SYMBOL_W'({1'b0, req.entry_index} + SHIFT_LO[SYMBOL_W-1:0]);
      if (req.entry_index == '0) begin
         query_char = delimiter;
      end else if (req.entry_index == INDEX_W'(1)) begin
         query_char = TAB_BYTE;
      end else if (char_base >= delimiter) begin
         query_char = char_base + 1'b1;
      end else begin
         query_char = char_base;
      end
   end

   always_comb begin
      q_entry.cmd       = CMD_ZERO;
      q_entry.bin       = '0;
      q_entry.char_code = '0;
      case (req_code_type'(req.req_type))
         REQ_COUNT: begin
            if (count_ok) begin
               q_entry.cmd = CMD_COUNT;
               q_entry.bin = bin_raw[INDEX_W-1:0];
            end
         end
         REQ_QUERY: begin
            q_entry.cmd       = query_ok ? CMD_QUERY : CMD_QUERY_OOR;
            q_entry.bin       = req.entry_index;
            q_entry.char_code = query_char;
         end
         REQ_CLEAR: begin
            q_entry.cmd = CMD_CLEAR;
         end
         default: begin
            q_entry.cmd = CMD_ZERO;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: hw/rtl/bshc_back.sv
// Back end: updates the bin counters, scans for prefix sums and drives results.
`default_nettype none
module bshc_back #(
   parameter int NUM_BINS   = 96,
   parameter int COUNT_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bshc_pkg::queue_status_type q_status,
   input  bshc_pkg::queue_entry_type  q_entry,
   output logic                       q_pop,
   output bshc_pkg::back_status_type  status,
   bshc_rsp_if.source                 rsp
);
   import bshc_pkg::*;

   localparam int ADDR_W = $clog2(NUM_BINS);
   localparam int SUM_W  = (COUNT_BITS + 8 > 33) ? COUNT_BITS + 8 : 33;

   back_state_type state_ff, state_in;

   logic [NUM_BINS-1:0]   valid_ff, valid_in;
   logic [ADDR_W-1:0]     addr_ff, addr_in;
   logic [ADDR_W-1:0]     target_ff, target_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   queue_entry_type       cur_ff, cur_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]    rsp_bin_ff, rsp_bin_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [OUT_CNT_W-1:0]  rsp_cnt_ff, rsp_cnt_in;
   logic [START_W-1:0]    rsp_start_ff, rsp_start_in;
   logic [SYMBOL_W-1:0]   rsp_char_ff, rsp_char_in;

   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [COUNT_BITS-1:0] rd_data;
   logic                  wr_en;

   logic                  out_free;
   logic                  head_ready;
   logic [ADDR_W-1:0]     head_addr;
   logic [COUNT_BITS-1:0] eff_count;
   logic [COUNT_BITS-1:0] inc_count;
   logic                  at_target;

   function automatic logic [OUT_CNT_W-1:0] clamp_out(input logic [SUM_W-1:0] v);
      logic [OUT_CNT_W-1:0] r;
      r = (|v[SUM_W-1:OUT_CNT_W]) ? '1 : v[OUT_CNT_W-1:0];
      return r;
   endfunction

   bshc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
   ) u_counts (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (inc_count),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign head_ready = !q_status.empty && out_free;
   assign head_addr  = ADDR_W'(q_entry.bin);
   // An entry never written since the last clear reads as zero.
   assign eff_count  = valid_ff[addr_ff] ? rd_data : '0;
   assign inc_count  = (eff_count == '1) ? eff_count : eff_count + 1'b1;
   assign at_target  = (addr_ff == target_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head_ready) begin
               if (q_entry.cmd == CMD_COUNT) begin
                  state_in = BK_COUNT;
               end else if (q_entry.cmd == CMD_QUERY) begin
                  state_in = BK_QUERY;
               end
            end
         end
         BK_COUNT: begin
            state_in = BK_IDLE;
         end
         BK_QUERY: begin
            if (at_target) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;
      wr_en        = 1'b0;
      valid_in     = valid_ff;
      addr_in      = addr_ff;
      target_in    = target_ff;
      sum_in       = sum_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_bin_in   = rsp_bin_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_start_in = rsp_start_ff;
      rsp_char_in  = rsp_char_ff;
      case (state_ff)
         BK_IDLE: begin
            if (head_ready) begin
               q_pop  = 1'b1;
               cur_in = q_entry;
               case (q_entry.cmd)
                  CMD_COUNT: begin
                     rd_en   = 1'b1;
                     rd_addr = head_addr;
                     addr_in = head_addr;
                  end
                  CMD_QUERY: begin
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                     addr_in   = '0;
                     target_in = head_addr;
                     sum_in    = '0;
                  end
                  CMD_QUERY_OOR: begin
                     rsp_valid_in = 1'b1;
                     rsp_bin_in   = q_entry.bin;
                     rsp_ok_in    = 1'b0;
                     rsp_cnt_in   = '0;
                     rsp_start_in = START_NONE;
                     rsp_char_in  = q_entry.char_code;
                  end
                  CMD_CLEAR: begin
                     valid_in     = '0;
                     rsp_valid_in = 1'b1;
                     rsp_bin_in   = '0;
                     rsp_ok_in    = 1'b0;
                     rsp_cnt_in   = '0;
                     rsp_start_in = '0;
                     rsp_char_in  = '0;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_bin_in   = '0;
                     rsp_ok_in    = 1'b0;
                     rsp_cnt_in   = '0;
                     rsp_start_in = '0;
                     rsp_char_in  = '0;
                  end
               endcase
            end
         end
         BK_COUNT: begin
            wr_en             = 1'b1;
            valid_in[addr_ff] = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_bin_in        = cur_ff.bin;
            rsp_ok_in         = 1'b1;
            rsp_cnt_in        = clamp_out(SUM_W'(inc_count));
            rsp_start_in      = '0;
            rsp_char_in       = '0;
         end
         BK_QUERY: begin
            if (at_target) begin
               rsp_valid_in = 1'b1;
               rsp_bin_in   = cur_ff.bin;
               rsp_ok_in    = 1'b1;
               rsp_cnt_in   = clamp_out(SUM_W'(eff_count));
               rsp_start_in = (eff_count == '0) ? START_NONE : {1'b0, clamp_out(sum_ff)};
               rsp_char_in  = cur_ff.char_code;
            end else begin
               sum_in  = sum_ff + SUM_W'(eff_count);
               addr_in = addr_ff + 1'b1;
               rd_en   = 1'b1;
               rd_addr = addr_ff + 1'b1;
            end
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      target_ff    <= target_in;
      sum_ff       <= sum_in;
      cur_ff       <= cur_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_start_ff <= rsp_start_in;
      rsp_char_ff  <= rsp_char_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.bin_index    = rsp_bin_ff;
   assign rsp.symbol_ok    = rsp_ok_ff;
   assign rsp.bin_count    = rsp_cnt_ff;
   assign rsp.start_offset = rsp_start_ff;
   assign rsp.entry_char   = rsp_char_ff;

   assign status.idle       = (state_ff == BK_IDLE);
   assign status.any_valid  = |valid_ff;
   assign status.clear_fire = q_pop && (q_entry.cmd == CMD_CLEAR);

endmodule
`default_nettype wire

FILE: tb/tb_bwt_symbol_histogram_ctable_unit.sv
// Self-checking testbench for the symbol histogram and C table unit.
`timescale 1ns / 100ps
module tb_bwt_symbol_histogram_ctable_unit;
   import bshc_pkg::*;

   localparam int NUM_BINS      = DEF_NUM_BINS;
   localparam int RESET_CYCLES  = 9;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int LONG_HOLD     = 120;
   localparam int SEGMENTS      = 6;
   localparam int SEGMENT_ITEMS = 64;
   // The slowest request is a query of the last bin, which reads every counter in turn.
   localparam int QUERY_LATENCY = NUM_BINS + 2;

   // One result item as the block presents it on the result channel.
   typedef struct packed {
      logic [INDEX_W-1:0]   bin;
      logic                 ok;
      logic [OUT_CNT_W-1:0] count;
      logic [START_W-1:0]   start;
      logic [SYMBOL_W-1:0]  chr;
   } ctable_reply_type;

   // The tracker keeps its own copy of the bin counters and the delimiter, works out the
   // result that each accepted request must produce, and matches the results in order.
   class histogram_tracker;
      logic [OUT_CNT_W-1:0] bin_counts [NUM_BINS];
      logic [SYMBOL_W-1:0]  delimiter;
      ctable_reply_type     pending_results [$];
      int                   mismatches;

      function new();
         foreach (bin_counts[i]) bin_counts[i] = '0;
         delimiter  = DELIM_RESET;
         mismatches = 0;
      endfunction

      // Bin of a text byte below 128; the value may fall outside the table.
      function int symbol_bin(logic [SYMBOL_W-1:0] c);
         if (c == delimiter) return 0;
         if (c == TAB_BYTE) return 1;
         if (c < delimiter) return int'(c) - 30;
         return int'(c) - 31;
      endfunction

      // Byte that a bin stands for, with the wrap at 256 in both steps.
      function logic [SYMBOL_W-1:0] bin_symbol(logic [INDEX_W-1:0] ix);
         logic [SYMBOL_W-1:0] c;
         if (ix == 0) return delimiter;
         if (ix == 1) return TAB_BYTE;
         c = {1'b0, ix} + 8'd30;
         if (c >= delimiter) c = c + 8'd1;
         return c;
      endfunction

      function void note_request(req_code_type kind, logic [SYMBOL_W-1:0] sym,
                                 logic [INDEX_W-1:0] ix);
         ctable_reply_type r;
         int               b;
         logic [63:0]      sum;
         r = '0;
         case (kind)
            REQ_COUNT: begin
               if (!sym[7]) begin
                  b = symbol_bin(sym);
                  if (b >= 0 && b < NUM_BINS) begin
                     if (bin_counts[b] != '1) bin_counts[b] = bin_counts[b] + 1'b1;
                     r.bin   = INDEX_W'(b);
                     r.ok    = 1'b1;
                     r.count = bin_counts[b];
                  end
               end
            end
            REQ_QUERY: begin
               r.bin = ix;
               r.chr = bin_symbol(ix);
               if (ix < NUM_BINS) begin
                  sum = '0;
                  for (int i = 0; i < ix; i++) sum += {32'b0, bin_counts[i]};
                  r.ok    = 1'b1;
                  r.count = bin_counts[ix];
                  if (bin_counts[ix] == '0) r.start = START_NONE;
                  else if (sum > 64'hFFFF_FFFF) r.start = {1'b0, 32'hFFFF_FFFF};
                  else r.start = {1'b0, sum[31:0]};
               end else begin
                  r.start = START_NONE;
               end
            end
            REQ_CLEAR: foreach (bin_counts[i]) bin_counts[i] = '0;
            default: ;
         endcase
         pending_results.push_back(r);
      endfunction

      function void check_result(ctable_reply_type got);
         ctable_reply_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with no request pending: bin %0d ok %0b count %0d start %0h char %0h",
                        got.bin, got.ok, got.count, got.start, got.chr);
            return;
         end
         want = pending_results.pop_front();
         if (got.bin !== want.bin || got.ok !== want.ok || got.count !== want.count ||
             got.start !== want.start || got.chr !== want.chr) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: expected bin %0d ok %0b count %0d start %0h char %0h",
                        want.bin, want.ok, want.count, want.start, want.chr);
               $display("          actual   bin %0d ok %0b count %0d start %0h char %0h",
                        got.bin, got.ok, got.count, got.start, got.chr);
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   bshc_req_if req_chan ();
   bshc_rsp_if rsp_chan ();
   bshc_csr_if csr_chan ();

   bwt_symbol_histogram_ctable_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   histogram_tracker tracker = new();

   // Idle percentages for the two sides; the main sequence changes them between phases.
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   // Set by the main sequence to ask the receiver for one long hold-off.
   bit stall_request = 1'b0;
   int cycle_count   = 0;

   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run instead of spinning forever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result side. Every accepted result is checked against the oldest expectation, and the
   // ready for the next edge is chosen at random, or held low during a long hold-off. The
   // hold-off is counted here, so the sender keeps offering items and the block fills up.
   initial begin
      ctable_reply_type got;
      int               hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
               got.bin   = rsp_chan.bin_index;
               got.ok    = rsp_chan.symbol_ok;
               got.count = rsp_chan.bin_count;
               got.start = rsp_chan.start_offset;
               got.chr   = rsp_chan.entry_char;
               tracker.check_result(got);
            end
            if (stall_request && hold_left == 0) begin
               hold_left     = LONG_HOLD;
               stall_request = 1'b0;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
         end
      end
   end

   // Offers one request item, idling at random first, and returns at the edge where it is
   // taken. Valid stays high so that the next item can follow without a gap; any code that
   // lets time pass outside this task lowers valid first.
   task automatic send_request(input req_code_type kind, input logic [SYMBOL_W-1:0] sym,
                               input logic [INDEX_W-1:0] ix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.req_type    <= kind;
      req_chan.symbol      <= sym;
      req_chan.entry_index <= ix;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_request(kind, sym, ix);
   endtask

   // Stops offering items and waits until every expected result has arrived, then lets the
   // given number of cycles pass so that a stray result would still be caught.
   task automatic drain_results(input int settle);
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      while (tracker.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (settle) @(posedge clock);
   endtask

   // Writes the delimiter register; only called while the block has nothing in flight.
   task automatic write_delimiter(input logic [SYMBOL_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.wdata <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      tracker.delimiter = value;
   endtask

   // Random request. Most items are text bytes that land in the table, with queries mixed
   // in to read back the running histogram; the rest are special bytes, rejected bytes,
   // out-of-range queries, clears and no-operation items.
   task automatic random_request();
      int                  roll;
      req_code_type        kind;
      logic [SYMBOL_W-1:0] sym;
      logic [INDEX_W-1:0]  ix;
      roll = $urandom_range(99);
      if (roll < 62) kind = REQ_COUNT;
      else if (roll < 89) kind = REQ_QUERY;
      else if (roll < 96) kind = REQ_NOP;
      else kind = REQ_CLEAR;
      sym = SYMBOL_W'($urandom_range(255));
      ix  = INDEX_W'($urandom_range(127));
      if (kind == REQ_COUNT) begin
         roll = $urandom_range(99);
         if (roll < 70) sym = SYMBOL_W'($urandom_range(30, 127));
         else if (roll < 78) sym = tracker.delimiter;
         else if (roll < 84) sym = TAB_BYTE;
         else if (roll < 92) sym = SYMBOL_W'($urandom_range(29));
         else sym = SYMBOL_W'($urandom_range(128, 255));
      end else if (kind == REQ_QUERY) begin
         roll = $urandom_range(99);
         if (roll < 78) ix = INDEX_W'($urandom_range(NUM_BINS - 1));
         else if (roll < 88) ix = INDEX_W'($urandom_range(1));
         else ix = INDEX_W'($urandom_range(NUM_BINS, 127));
      end
      send_request(kind, sym, ix);
   endtask

   initial begin
      logic [SYMBOL_W-1:0] delim_plan [SEGMENTS];
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.req_type    <= REQ_NOP;
      req_chan.symbol      <= '0;
      req_chan.entry_index <= '0;
      csr_chan.valid       <= 1'b0;
      csr_chan.wdata       <= '0;

      // Delimiter settings for the random phases: both extremes, tab itself, the first
      // byte above the text range, and two random values.
      delim_plan[0] = 8'd0;
      delim_plan[1] = 8'd255;
      delim_plan[2] = TAB_BYTE;
      delim_plan[3] = 8'd128;
      delim_plan[4] = SYMBOL_W'($urandom_range(30, 127));
      delim_plan[5] = SYMBOL_W'($urandom_range(255));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The first phase has the sender idle a quarter of the time and the receiver about
      // half of it.
      send_idle_pct = 25;
      recv_idle_pct = 53;

      // Directed part with the reset delimiter written back explicitly. It covers the
      // delimiter and tab bytes, bytes on both sides of the delimiter, the first and last
      // bytes that land in the table, bytes that fall below or above it, bytes above 127,
      // queries of the first, last, empty and out-of-range bins, a no-operation item with
      // all fields at their maximum, and a clear followed by a query.
      write_delimiter(DELIM_RESET);
      send_request(REQ_COUNT, 8'd36, 7'd0);
      send_request(REQ_COUNT, TAB_BYTE, 7'd0);
      send_request(REQ_COUNT, 8'd30, 7'd0);
      send_request(REQ_COUNT, 8'd35, 7'd0);
      send_request(REQ_COUNT, 8'd37, 7'd0);
      send_request(REQ_COUNT, 8'd126, 7'd0);
      send_request(REQ_COUNT, 8'd127, 7'd0);
      send_request(REQ_COUNT, 8'd29, 7'd0);
      send_request(REQ_COUNT, 8'd0, 7'd0);
      send_request(REQ_COUNT, 8'd128, 7'd0);
      send_request(REQ_COUNT, 8'd255, 7'd127);
      send_request(REQ_QUERY, 8'd0, 7'd0);
      send_request(REQ_QUERY, 8'd0, 7'd1);
      send_request(REQ_QUERY, 8'd0, 7'd2);
      send_request(REQ_QUERY, 8'd0, 7'd5);
      send_request(REQ_QUERY, 8'd0, 7'd6);
      send_request(REQ_QUERY, 8'd255, 7'd95);
      send_request(REQ_QUERY, 8'd0, 7'd96);
      send_request(REQ_QUERY, 8'd0, 7'd127);
      send_request(REQ_NOP, 8'd255, 7'd127);
      send_request(REQ_CLEAR, 8'd255, 7'd127);
      send_request(REQ_QUERY, 8'd0, 7'd0);
      send_request(REQ_COUNT, 8'd65, 7'd0);
      send_request(REQ_QUERY, 8'd0, 7'd35);

      // Random phases, each under its own delimiter. The register is only written once the
      // block has returned every result, so no request in flight sees the change.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_results(4);
         write_delimiter(delim_plan[seg]);
         if (seg == 2) begin
            send_idle_pct = 53;
            recv_idle_pct = 25;
         end else if (seg == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int n = 0; n < SEGMENT_ITEMS; n++) begin
            // A long hold-off on the result side while items keep coming, so that the
            // internal queue fills and the block has to stall its input.
            if ((seg == 1 || seg == 4) && n == 8) stall_request = 1'b1;
            // One pause on the request side mid-phase until everything has come back.
            if (seg == 3 && n == 32) drain_results(0);
            random_request();
         end
      end

      // Let the slowest possible request finish so that an extra result would be seen.
      drain_results(QUERY_LATENCY + 8);
      if (tracker.pending_results.size() != 0)
         $display("%0d expected results never arrived", tracker.pending_results.size());
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

FILE: bwt_symbol_histogram_ctable_unit.f
+incdir+hw/rtl
hw/rtl/bshc_pkg.sv
hw/rtl/bshc_channels.sv
hw/rtl/bshc_ram.sv
hw/rtl/bshc_queue.sv
hw/rtl/bshc_front.sv
hw/rtl/bshc_back.sv
hw/rtl/bwt_symbol_histogram_ctable_unit.sv
tb/tb_bwt_symbol_histogram_ctable_unit.sv
